// ===== hdl/mbbp_pkg.sv =====
// Shared types and constants for the monochrome bitmap byte packer.
// No dependencies; used by mbbp_out_fifo and mono_bitmap_byte_packer.
package mbbp_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;

    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int ROW_W    = $clog2(MAX_HEIGHT);
    localparam int WIDTH_W  = 11;
    localparam int HEIGHT_W = 13;
    localparam int CFG_W    = 13;
    localparam int PIX_W    = 8;
    localparam int BYTE_W   = 8;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd128;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd64;

    typedef enum logic [1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_HORIZONTAL   = 2'd2,
        CFG_INVERT       = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_FIRST,
        OP_ACCUM,
        OP_EMIT,
        OP_HBYTE
    } s1_op_t;

    typedef struct packed {
        logic              push;
        logic [BYTE_W-1:0] data;
    } out_push_t;

endpackage

// ===== hdl/mono_bitmap_byte_packer.sv =====
// Top level of the monochrome bitmap byte packer: position tracking, column store
// and read-modify-write stage. Depends on mbbp_pkg and mbbp_out_fifo.
//
// Takes pixel words and gives zero or one packed byte per pixel via the stage 1
// register and the output queue. The rate is one pixel per cycle when not stalled,
// set by the column store, which is read when a pixel is taken and written back by
// the next stage in the following cycle; a write and a read of the same column in
// one cycle are forwarded. The store needs no clearing pass after reset. A
// three-word output queue lets input continue while a result waits; input stalls
// only while that queue and the pipeline stage together hold three words.
module mono_bitmap_byte_packer
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [mbbp_pkg::PIX_W-1:0]    s_tdata,    // blue_level [7:0]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [mbbp_pkg::BYTE_W-1:0]   m_tdata,    // packed_byte [7:0]
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [mbbp_pkg::CFG_W-1:0]    cfg_data
);

    localparam int COL_W    = mbbp_pkg::COL_W;
    localparam int ROW_W    = mbbp_pkg::ROW_W;
    localparam int WIDTH_W  = mbbp_pkg::WIDTH_W;
    localparam int HEIGHT_W = mbbp_pkg::HEIGHT_W;
    localparam int BYTE_W   = mbbp_pkg::BYTE_W;

    // configuration
    logic [WIDTH_W-1:0]  image_width_reg;
    logic [HEIGHT_W-1:0] image_height_reg;
    logic                horizontal_mode_reg;
    logic                invert_pixels_reg;

    // stream position and horizontal accumulator
    logic [COL_W-1:0]  col_pos_reg, col_pos_next;
    logic [ROW_W-1:0]  row_pos_reg, row_pos_next;
    logic [BYTE_W-1:0] hacc_reg, hacc_next;
    logic [2:0]        hcount_reg, hcount_next;

    // read-modify-write stage
    logic                 s1_valid_reg;
    mbbp_pkg::s1_op_t     s1_op_reg, s1_op_next;
    logic [COL_W-1:0]     s1_col_reg;
    logic                 s1_bit_reg;
    logic [2:0]           s1_r_reg;
    logic [BYTE_W-1:0]    s1_hbyte_reg, s1_hbyte_next;
    logic                 fwd_hit_reg;
    logic [BYTE_W-1:0]    fwd_data_reg;

    logic [BYTE_W-1:0] col_store [mbbp_pkg::MAX_WIDTH];
    logic [BYTE_W-1:0] ram_q_reg;

    logic                accept;
    logic                pix_bit;
    logic [WIDTH_W-1:0]  width_eff;
    logic [HEIGHT_W-1:0] height_eff;
    logic [HEIGHT_W-1:0] full_rows;
    logic                in_page;
    logic                last_col;
    logic                last_row;
    logic [2:0]          row_lsb;

    logic                 wr_en;
    logic [BYTE_W-1:0]    wr_data;
    logic [BYTE_W-1:0]    rd_val;
    mbbp_pkg::out_push_t  out_push;
    logic [1:0]           fifo_count;

    assign s_tready = ({1'b0, fifo_count} + {2'b00, s1_valid_reg}) < 3'd3;
    assign accept   = s_tvalid && s_tready;
    assign pix_bit  = (s_tdata == '0) ^ invert_pixels_reg;

    always_comb
    begin
        if (image_width_reg == '0)
            width_eff = WIDTH_W'(1);
        else if (image_width_reg > WIDTH_W'(mbbp_pkg::MAX_WIDTH))
            width_eff = WIDTH_W'(mbbp_pkg::MAX_WIDTH);
        else
            width_eff = image_width_reg;

        if (image_height_reg == '0)
            height_eff = HEIGHT_W'(1);
        else if (image_height_reg > HEIGHT_W'(mbbp_pkg::MAX_HEIGHT))
            height_eff = HEIGHT_W'(mbbp_pkg::MAX_HEIGHT);
        else
            height_eff = image_height_reg;
    end

    assign full_rows = {height_eff[HEIGHT_W-1:3], 3'b000};
    assign in_page   = {{(HEIGHT_W-ROW_W){1'b0}}, row_pos_reg} < full_rows;
    assign last_col  = ({{(WIDTH_W-COL_W){1'b0}}, col_pos_reg} + WIDTH_W'(1)) >= width_eff;
    assign last_row  = ({{(HEIGHT_W-ROW_W){1'b0}}, row_pos_reg} + HEIGHT_W'(1)) >= height_eff;
    assign row_lsb   = row_pos_reg[2:0];

    // stage 0: classify the pixel and advance the position
    always_comb
    begin
        col_pos_next  = col_pos_reg;
        row_pos_next  = row_pos_reg;
        hacc_next     = hacc_reg;
        hcount_next   = hcount_reg;
        s1_op_next    = mbbp_pkg::OP_NONE;
        s1_hbyte_next = hacc_reg | (BYTE_W'(pix_bit) << 7);

        if (horizontal_mode_reg)
        begin
            if (hcount_reg == 3'd7)
            begin
                s1_op_next  = mbbp_pkg::OP_HBYTE;
                hacc_next   = '0;
                hcount_next = 3'd0;
            end
            else
            begin
                hacc_next   = hacc_reg | (BYTE_W'(pix_bit) << hcount_reg);
                hcount_next = hcount_reg + 3'd1;
            end
        end
        else if (in_page)
        begin
            case (row_lsb)
                3'd0:    s1_op_next = mbbp_pkg::OP_FIRST;
                3'd7:    s1_op_next = mbbp_pkg::OP_EMIT;
                default: s1_op_next = mbbp_pkg::OP_ACCUM;
            endcase
        end

        if (last_col)
        begin
            col_pos_next = '0;
            if (last_row)
            begin
                row_pos_next = '0;
                hacc_next    = '0;
                hcount_next  = 3'd0;
            end
            else
            begin
                row_pos_next = row_pos_reg + ROW_W'(1);
            end
        end
        else
        begin
            col_pos_next = col_pos_reg + COL_W'(1);
        end
    end

    // stage 1: merge with the column store and write back or emit
    assign rd_val = fwd_hit_reg ? fwd_data_reg : ram_q_reg;

    always_comb
    begin
        wr_en         = 1'b0;
        wr_data       = rd_val | (BYTE_W'(s1_bit_reg) << s1_r_reg);
        out_push.push = 1'b0;
        out_push.data = rd_val | (BYTE_W'(s1_bit_reg) << 7);
        if (s1_valid_reg)
        begin
            case (s1_op_reg)
                mbbp_pkg::OP_FIRST:
                begin
                    wr_en   = 1'b1;
                    wr_data = BYTE_W'(s1_bit_reg);
                end
                mbbp_pkg::OP_ACCUM:
                begin
                    wr_en = 1'b1;
                end
                mbbp_pkg::OP_EMIT:
                begin
                    out_push.push = 1'b1;
                end
                mbbp_pkg::OP_HBYTE:
                begin
                    out_push.push = 1'b1;
                    out_push.data = s1_hbyte_reg;
                end
                default:
                begin
                    wr_en = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg     <= mbbp_pkg::WIDTH_RESET;
            image_height_reg    <= mbbp_pkg::HEIGHT_RESET;
            horizontal_mode_reg <= 1'b0;
            invert_pixels_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mbbp_pkg::CFG_IMAGE_WIDTH:  image_width_reg     <= cfg_data[WIDTH_W-1:0];
                mbbp_pkg::CFG_IMAGE_HEIGHT: image_height_reg    <= cfg_data[HEIGHT_W-1:0];
                mbbp_pkg::CFG_HORIZONTAL:   horizontal_mode_reg <= cfg_data[0];
                mbbp_pkg::CFG_INVERT:       invert_pixels_reg   <= cfg_data[0];
                default:                    invert_pixels_reg   <= invert_pixels_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_pos_reg  <= '0;
            row_pos_reg  <= '0;
            hacc_reg     <= '0;
            hcount_reg   <= 3'd0;
            s1_valid_reg <= 1'b0;
            s1_op_reg    <= mbbp_pkg::OP_NONE;
            fwd_hit_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            fwd_hit_reg  <= accept && wr_en && (s1_col_reg == col_pos_reg);
            if (accept)
            begin
                col_pos_reg <= col_pos_next;
                row_pos_reg <= row_pos_next;
                hacc_reg    <= hacc_next;
                hcount_reg  <= hcount_next;
                s1_op_reg   <= s1_op_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_data_reg <= wr_data;
        if (accept)
        begin
            s1_col_reg   <= col_pos_reg;
            s1_bit_reg   <= pix_bit;
            s1_r_reg     <= row_lsb;
            s1_hbyte_reg <= s1_hbyte_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ram_q_reg <= col_store[col_pos_reg];
        end
        if (wr_en)
        begin
            col_store[s1_col_reg] <= wr_data;
        end
    end

    mbbp_out_fifo u_out_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (out_push),
        .count    (fifo_count),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== hdl/mbbp_out_fifo.sv =====
// Three-word output queue that parts the packing pipeline from the output stream.
// Depends on mbbp_pkg.
module mbbp_out_fifo
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  mbbp_pkg::out_push_t        wr,
    output logic [1:0]                 count,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [mbbp_pkg::BYTE_W-1:0] m_tdata   // packed_byte [7:0]
);

    localparam logic [1:0] LAST_SLOT = 2'd2;

    logic [mbbp_pkg::BYTE_W-1:0] slot_reg [3];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign pop      = m_tvalid && m_tready;
    assign m_tvalid = (count_reg != 2'd0);
    assign m_tdata  = slot_reg[rd_ptr_reg];
    assign count    = count_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr.push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? 2'd0 : wr_ptr_reg + 2'd1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? 2'd0 : rd_ptr_reg + 2'd1;
        end
        if (wr.push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!wr.push && pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.push)
        begin
            slot_reg[wr_ptr_reg] <= wr.data;
        end
    end

endmodule
